/* hw/rtl/wgt_pkg.sv */
// Shared types and constants for the weighted grey with tint block.
// Used by wgt_grey, wgt_tint and weighted_grey_with_tint; depends on nothing.

package wgt_pkg;

   // field widths fixed by the pixel and register formats
   localparam int FRAC_BITS_DEF = 10;
   localparam int PIX_W         = 8;
   localparam int WEIGHT_W      = 13;
   localparam int HUE_W         = 10;
   localparam int SAT_W         = 11;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = WEIGHT_W;

   // pipeline split: grey path stages, then tint path stages
   localparam int GREY_STAGES = 4;
   localparam int TINT_STAGES = 6;
   localparam int NUM_STAGES  = GREY_STAGES + TINT_STAGES;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WEIGHT_RED     = 3'd0,
      REG_WEIGHT_GREEN   = 3'd1,
      REG_WEIGHT_BLUE    = 3'd2,
      REG_WEIGHT_YELLOW  = 3'd3,
      REG_WEIGHT_CYAN    = 3'd4,
      REG_WEIGHT_MAGENTA = 3'd5,
      REG_TINT_HUE       = 3'd6,
      REG_TINT_SAT       = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
      logic [PIX_W-1:0] alpha_in;
   } pixel_in_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
      logic [PIX_W-1:0] alpha_out;
   } pixel_out_type;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight_red;
      logic signed [WEIGHT_W-1:0] weight_green;
      logic signed [WEIGHT_W-1:0] weight_blue;
      logic signed [WEIGHT_W-1:0] weight_yellow;
      logic signed [WEIGHT_W-1:0] weight_cyan;
      logic signed [WEIGHT_W-1:0] weight_magenta;
      logic        [HUE_W-1:0]    tint_hue;
      logic        [SAT_W-1:0]    tint_saturation;
   } csr_type;

   localparam csr_type CSR_RESET = '{
      weight_red:      13'sd410,
      weight_green:    13'sd410,
      weight_blue:     13'sd205,
      weight_yellow:   13'sd614,
      weight_cyan:     13'sd614,
      weight_magenta:  13'sd819,
      tint_hue:        10'd0,
      tint_saturation: 11'd0
   };

endpackage

/* hw/rtl/wgt_grey.sv */
// Grey path: channel sort, weight select, weighted sum, clamp, lightness estimate.
// Four register stages; uses wgt_pkg.

module wgt_grey #(
   parameter int FRAC_BITS = wgt_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic [wgt_pkg::GREY_STAGES-1:0]     stage_en,
   input  wgt_pkg::pixel_in_type               req_data,
   input  wgt_pkg::csr_type                    csr,
   output logic [FRAC_BITS:0]                  light_est,
   output logic [FRAC_BITS+7:0]                light_num,
   output logic [wgt_pkg::PIX_W-1:0]           grey_byte,
   output logic [wgt_pkg::PIX_W-1:0]           alpha
);
   import wgt_pkg::*;

   localparam int PROD_W = PIX_W + 1 + WEIGHT_W;
   // room for the base term and the full 13-bit signed weight span
   localparam int GN_W   =
      ((FRAC_BITS + PIX_W + 1 > PROD_W) ? FRAC_BITS + PIX_W + 1 : PROD_W) + 1;
   localparam int GC_W   = FRAC_BITS + PIX_W;
   localparam int LP_W   = GC_W + FRAC_BITS + 1;
   localparam logic signed [GN_W-1:0] GN_MAX = GN_W'(255 << FRAC_BITS);
   // floor(2^GC_W / 255), good to within one for any value below 2^GC_W
   localparam logic [FRAC_BITS:0] RECIP =
      (FRAC_BITS+1)'((64'd1 << GC_W) / 64'd255);
   localparam logic [GC_W:0] HALF_LSB = (GC_W+1)'(1) << (FRAC_BITS - 1);

   // stage 1 registers
   logic [PIX_W-1:0]           s1_min_ff, s1_lo_ff, s1_hi_ff, s1_alpha_ff;
   logic signed [WEIGHT_W-1:0] s1_wp_ff, s1_ws_ff;
   logic [PIX_W-1:0]           s1_min_in, s1_lo_in, s1_hi_in;
   logic signed [WEIGHT_W-1:0] s1_wp_in, s1_ws_in;
   // stage 2 registers
   logic signed [PROD_W-1:0]   s2_plo_ff, s2_phi_ff, s2_plo_in, s2_phi_in;
   logic [PIX_W-1:0]           s2_min_ff, s2_alpha_ff;
   // stage 3 registers
   logic [GC_W-1:0]            s3_gc_ff, s3_gc_in;
   logic [PIX_W-1:0]           s3_alpha_ff;
   // stage 4 registers
   logic [FRAC_BITS:0]         s4_est_ff, s4_est_in;
   logic [GC_W-1:0]            s4_num_ff, s4_num_in;
   logic [PIX_W-1:0]           s4_grey_ff, s4_grey_in, s4_alpha_ff;

   logic [PIX_W-1:0]           r, g, b, mx, mn;
   logic [PIX_W+1:0]           mid_w;
   logic signed [GN_W-1:0]     gn_sum;
   logic [LP_W-1:0]            lp;
   logic [GC_W:0]              grey_rnd;
   logic [PIX_W:0]             grey_w;

   // sort channels and pick weights; ties go to red, then green for the max and to blue, then red for the min
   always_comb begin
      r = req_data.red_in;
      g = req_data.green_in;
      b = req_data.blue_in;
      mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      mid_w = (PIX_W+2)'(r) + (PIX_W+2)'(g) + (PIX_W+2)'(b)
            - (PIX_W+2)'(mx) - (PIX_W+2)'(mn);
      s1_min_in = mn;
      s1_lo_in  = mid_w[PIX_W-1:0] - mn;
      s1_hi_in  = mx - mid_w[PIX_W-1:0];
      if (mx == r) begin
         s1_wp_in = csr.weight_red;
      end else if (mx == g) begin
         s1_wp_in = csr.weight_green;
      end else begin
         s1_wp_in = csr.weight_blue;
      end
      if (mn == b) begin
         s1_ws_in = csr.weight_yellow;
      end else if (mn == r) begin
         s1_ws_in = csr.weight_cyan;
      end else begin
         s1_ws_in = csr.weight_magenta;
      end
   end

   // weight products
   always_comb begin
      s2_plo_in = PROD_W'($signed({1'b0, s1_lo_ff})) * PROD_W'(s1_ws_ff);
      s2_phi_in = PROD_W'($signed({1'b0, s1_hi_ff})) * PROD_W'(s1_wp_ff);
   end

   // weighted sum and clamp to 0..255 in fixed point
   always_comb begin
      gn_sum = $signed(GN_W'({s2_min_ff, {FRAC_BITS{1'b0}}}))
             + GN_W'(s2_plo_ff) + GN_W'(s2_phi_ff);
      if (gn_sum < 0) begin
         s3_gc_in = '0;
      end else if (gn_sum > GN_MAX) begin
         s3_gc_in = GN_MAX[GC_W-1:0];
      end else begin
         s3_gc_in = gn_sum[GC_W-1:0];
      end
   end

   // lightness = floor((gc + 127) / 255), estimate by reciprocal; plain grey byte
   always_comb begin
      s4_num_in = s3_gc_ff + GC_W'(127);
      lp        = LP_W'(s4_num_in) * LP_W'(RECIP);
      s4_est_in = lp[LP_W-1:GC_W];
      grey_rnd  = {1'b0, s3_gc_ff} + HALF_LSB;
      grey_w    = grey_rnd[GC_W:FRAC_BITS];
      s4_grey_in = (grey_w > (PIX_W+1)'(255)) ? PIX_W'(255) : grey_w[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_min_ff   <= s1_min_in;
         s1_lo_ff    <= s1_lo_in;
         s1_hi_ff    <= s1_hi_in;
         s1_wp_ff    <= s1_wp_in;
         s1_ws_ff    <= s1_ws_in;
         s1_alpha_ff <= req_data.alpha_in;
      end
      if (stage_en[1]) begin
         s2_plo_ff   <= s2_plo_in;
         s2_phi_ff   <= s2_phi_in;
         s2_min_ff   <= s1_min_ff;
         s2_alpha_ff <= s1_alpha_ff;
      end
      if (stage_en[2]) begin
         s3_gc_ff    <= s3_gc_in;
         s3_alpha_ff <= s2_alpha_ff;
      end
      if (stage_en[3]) begin
         s4_est_ff   <= s4_est_in;
         s4_num_ff   <= s4_num_in;
         s4_grey_ff  <= s4_grey_in;
         s4_alpha_ff <= s3_alpha_ff;
      end
   end

   assign light_est = s4_est_ff;
   assign light_num = s4_num_ff;
   assign grey_byte = s4_grey_ff;
   assign alpha     = s4_alpha_ff;

endmodule

/* hw/rtl/wgt_tint.sv */
// Tint path: lightness correction, HSL q/p terms, per-channel ramp, byte rounding
// and the output register. Six register stages; uses wgt_pkg.

module wgt_tint #(
   parameter int FRAC_BITS = wgt_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic [wgt_pkg::TINT_STAGES-1:0]     stage_en,
   input  wgt_pkg::csr_type                    csr,
   input  logic [FRAC_BITS:0]                  light_est,
   input  logic [FRAC_BITS+7:0]                light_num,
   input  logic [wgt_pkg::PIX_W-1:0]           grey_byte,
   input  logic [wgt_pkg::PIX_W-1:0]           alpha,
   output wgt_pkg::pixel_out_type              rsp_data
);
   import wgt_pkg::*;

   localparam int L_W    = FRAC_BITS + 1;
   localparam int R_W    = FRAC_BITS + PIX_W + 1;
   localparam int CMP_W  = SAT_W + FRAC_BITS + 1;
   localparam int Q_W    = 2 * FRAC_BITS + 2;
   localparam int D_W    = 2 * FRAC_BITS + 1;
   localparam int M_W    = 3 * FRAC_BITS + 1;
   localparam int B_W    = M_W + PIX_W;
   localparam int H6_W   = FRAC_BITS + 4;
   localparam int CARRY  = TINT_STAGES - 1;
   localparam logic [L_W-1:0]  ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [L_W-1:0]  HALF = ONE >> 1;
   localparam logic [H6_W-1:0] T_ONE   = H6_W'(ONE);
   localparam logic [H6_W-1:0] T_TWO   = H6_W'(2) << FRAC_BITS;
   localparam logic [H6_W-1:0] T_THREE = H6_W'(3) << FRAC_BITS;
   localparam logic [H6_W-1:0] T_FOUR  = H6_W'(4) << FRAC_BITS;
   localparam logic [H6_W-1:0] T_SIX   = H6_W'(6) << FRAC_BITS;
   localparam logic [B_W-1:0]  ROUND   = B_W'(1) << (3 * FRAC_BITS - 1);

   // ramp factor for one channel: rise, hold at one, fall, zero
   function automatic logic [L_W-1:0] ramp(input logic [H6_W-1:0] t);
      logic [H6_W-1:0] fall;
      logic [L_W-1:0]  f;
      fall = T_FOUR - t;
      if (t < T_ONE) begin
         f = t[L_W-1:0];
      end else if (t < T_THREE) begin
         f = ONE;
      end else if (t < T_FOUR) begin
         f = fall[L_W-1:0];
      end else begin
         f = '0;
      end
      return f;
   endfunction

   logic [L_W-1:0]   s5_l_ff, s5_l_in;
   logic [2*L_W-1:0] s6_ls_ff, s6_ls_in;
   logic [L_W-1:0]   s6_l_ff;
   logic [D_W-1:0]   s7_p_ff, s7_p_in, s7_d_ff, s7_d_in;
   logic [D_W-1:0]   s8_p_ff;
   logic [M_W-1:0]   s8_m_ff [0:2];
   logic [M_W-1:0]   s8_m_in [0:2];
   logic [M_W-1:0]   s9_c_ff [0:2];
   logic [M_W-1:0]   s9_c_in [0:2];
   logic [L_W-1:0]   hue_fac_ff [0:2];
   logic [L_W-1:0]   hue_fac_in [0:2];
   logic [PIX_W-1:0] alpha_pipe_ff [0:CARRY-1];
   logic [PIX_W-1:0] grey_pipe_ff [0:CARRY-1];
   pixel_out_type    out_ff, out_in;

   logic [R_W-1:0]   est255, rem;
   logic [L_W-1:0]   l_fix;
   logic [CMP_W-1:0] sat_wide;
   logic [L_W-1:0]   sat_c;
   logic [Q_W-1:0]   l_sh, s_sh, q_w, p_w, d_w;
   logic [HUE_W+FRAC_BITS-1:0] hue_ext;
   logic [H6_W-1:0]  h6, t_red, t_blue;
   logic [2*M_W-1:0] m_full [0:2];
   logic [M_W:0]     c_full [0:2];
   logic [B_W-1:0]   b_full [0:2];
   logic [PIX_W:0]   b_byte [0:2];
   logic [PIX_W-1:0] chan [0:2];

   // saturation above one acts as one
   always_comb begin
      sat_wide = CMP_W'(csr.tint_saturation);
      sat_c    = (sat_wide > CMP_W'(ONE)) ? ONE : sat_wide[L_W-1:0];
   end

   // hue ramp factors are registered from the registers and do not stall with the pipeline
   always_comb begin
      hue_ext = (HUE_W+FRAC_BITS)'(csr.tint_hue);
      h6      = H6_W'(hue_ext[FRAC_BITS-1:0]) * H6_W'(6);
      t_red   = h6 + T_TWO;
      if (t_red >= T_SIX) begin
         t_red = t_red - T_SIX;
      end
      t_blue  = h6 + T_FOUR;
      if (t_blue >= T_SIX) begin
         t_blue = t_blue - T_SIX;
      end
      hue_fac_in[0] = ramp(t_red);
      hue_fac_in[1] = ramp(h6);
      hue_fac_in[2] = ramp(t_blue);
   end

   // stage 5: the estimate is low by at most one, fix with one compare
   always_comb begin
      est255 = {light_est, {PIX_W{1'b0}}} - R_W'(light_est);
      rem    = R_W'(light_num) - est255;
      l_fix  = (rem >= R_W'(255)) ? light_est + L_W'(1) : light_est;
      s5_l_in = (l_fix > ONE) ? ONE : l_fix;
   end

   // stage 6: lightness times saturation
   assign s6_ls_in = (2*L_W)'(s5_l_ff) * (2*L_W)'(sat_c);

   // stage 7: q and p with two fraction fields, keep p and q - p
   always_comb begin
      l_sh = Q_W'({s6_l_ff, {FRAC_BITS{1'b0}}});
      s_sh = Q_W'({sat_c, {FRAC_BITS{1'b0}}});
      if (s6_l_ff < HALF) begin
         q_w = l_sh + Q_W'(s6_ls_ff);
      end else begin
         q_w = l_sh + s_sh - Q_W'(s6_ls_ff);
      end
      p_w = Q_W'({s6_l_ff, {(FRAC_BITS+1){1'b0}}}) - q_w;
      d_w = q_w - p_w;
      s7_p_in = p_w[D_W-1:0];
      s7_d_in = d_w[D_W-1:0];
   end

   // stages 8 to 10 per channel: ramp product, add base, scale to a byte
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_full[i]  = (2*M_W)'(s7_d_ff) * (2*M_W)'(hue_fac_ff[i]);
         s8_m_in[i] = m_full[i][M_W-1:0];
         c_full[i]  = (M_W+1)'({s8_p_ff, {FRAC_BITS{1'b0}}}) + (M_W+1)'(s8_m_ff[i]);
         s9_c_in[i] = c_full[i][M_W-1:0];
         b_full[i]  = {s9_c_ff[i], {PIX_W{1'b0}}} - B_W'(s9_c_ff[i]) + ROUND;
         b_byte[i]  = b_full[i][B_W-1:3*FRAC_BITS];
         chan[i]    = (b_byte[i] > (PIX_W+1)'(255)) ? PIX_W'(255) : b_byte[i][PIX_W-1:0];
      end
   end

   // output word: plain grey when saturation is zero
   always_comb begin
      if (csr.tint_saturation == '0) begin
         out_in.red_out   = grey_pipe_ff[CARRY-1];
         out_in.green_out = grey_pipe_ff[CARRY-1];
         out_in.blue_out  = grey_pipe_ff[CARRY-1];
      end else begin
         out_in.red_out   = chan[0];
         out_in.green_out = chan[1];
         out_in.blue_out  = chan[2];
      end
      out_in.alpha_out = alpha_pipe_ff[CARRY-1];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         hue_fac_ff[i] <= hue_fac_in[i];
      end
      if (stage_en[0]) begin
         s5_l_ff          <= s5_l_in;
         alpha_pipe_ff[0] <= alpha;
         grey_pipe_ff[0]  <= grey_byte;
      end
      for (int i = 1; i < CARRY; i++) begin
         if (stage_en[i]) begin
            alpha_pipe_ff[i] <= alpha_pipe_ff[i-1];
            grey_pipe_ff[i]  <= grey_pipe_ff[i-1];
         end
      end
      if (stage_en[1]) begin
         s6_ls_ff <= s6_ls_in;
         s6_l_ff  <= s5_l_ff;
      end
      if (stage_en[2]) begin
         s7_p_ff <= s7_p_in;
         s7_d_ff <= s7_d_in;
      end
      if (stage_en[3]) begin
         s8_p_ff <= s7_p_ff;
         for (int i = 0; i < 3; i++) begin
            s8_m_ff[i] <= s8_m_in[i];
         end
      end
      if (stage_en[4]) begin
         for (int i = 0; i < 3; i++) begin
            s9_c_ff[i] <= s9_c_in[i];
         end
      end
      if (stage_en[5]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

endmodule

/* hw/rtl/weighted_grey_with_tint.sv */
// Top level: register file, pipeline valid chain, grey and tint datapaths.
// Uses wgt_pkg, wgt_grey and wgt_tint.
//
//   port group  direction  flow control     word
//   req_*       in         valid / stall    wgt_pkg::pixel_in_type
//   rsp_*       out        valid / stall    wgt_pkg::pixel_out_type
//   csr_*       in         valid / ready    3-bit register index, 13-bit data
//
// One pixel per clock sustained while the output is not stalled; rsp_valid is the valid
// bit of the last of the ten register stages of the datapath.
// Each stage loads when it is empty or the stage after it moves, so bubbles close up
// and input is taken while a finished word is held on a stalled output.
// Synchronous reset clears all stage valid bits and loads register reset values.
// csr_ready is always high; the hue factors are registered again from the register file.

module weighted_grey_with_tint #(
   parameter int FRAC_BITS = wgt_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  wgt_pkg::pixel_in_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output wgt_pkg::pixel_out_type             rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wgt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wgt_pkg::CSR_DATA_W-1:0]     csr_data
);
   import wgt_pkg::*;

   csr_type                 csr_ff, csr_in;
   logic [NUM_STAGES-1:0]   stage_valid_ff, stage_valid_in;
   logic [NUM_STAGES-1:0]   stage_ready;
   logic [FRAC_BITS:0]      light_est;
   logic [FRAC_BITS+7:0]    light_num;
   logic [PIX_W-1:0]        grey_byte, alpha;

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            REG_WEIGHT_RED:     csr_in.weight_red     = csr_data;
            REG_WEIGHT_GREEN:   csr_in.weight_green   = csr_data;
            REG_WEIGHT_BLUE:    csr_in.weight_blue    = csr_data;
            REG_WEIGHT_YELLOW:  csr_in.weight_yellow  = csr_data;
            REG_WEIGHT_CYAN:    csr_in.weight_cyan    = csr_data;
            REG_WEIGHT_MAGENTA: csr_in.weight_magenta = csr_data;
            REG_TINT_HUE:       csr_in.tint_hue       = csr_data[HUE_W-1:0];
            REG_TINT_SAT:       csr_in.tint_saturation = csr_data[SAT_W-1:0];
            default:            csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // stage ready chain from the output back to the input
   always_comb begin
      stage_ready[NUM_STAGES-1] = !stage_valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_ready[i] = !stage_valid_ff[i] || stage_ready[i+1];
      end
   end

   // valid bits travel with the data
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (stage_ready[0]) begin
         stage_valid_in[0] = req_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (stage_ready[i]) begin
            stage_valid_in[i] = stage_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign req_stall = !stage_ready[0];
   assign rsp_valid = stage_valid_ff[NUM_STAGES-1];

   // datapath
   wgt_grey #(
      .FRAC_BITS (FRAC_BITS)
   ) u_grey (
      .clock     (clock),
      .stage_en  (stage_ready[GREY_STAGES-1:0]),
      .req_data  (req_data),
      .csr       (csr_ff),
      .light_est (light_est),
      .light_num (light_num),
      .grey_byte (grey_byte),
      .alpha     (alpha)
   );

   wgt_tint #(
      .FRAC_BITS (FRAC_BITS)
   ) u_tint (
      .clock     (clock),
      .stage_en  (stage_ready[NUM_STAGES-1:GREY_STAGES]),
      .csr       (csr_ff),
      .light_est (light_est),
      .light_num (light_num),
      .grey_byte (grey_byte),
      .alpha     (alpha),
      .rsp_data  (rsp_data)
   );

   // checks
   // input backpressure only when every stage holds a word
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&stage_valid_ff))
      else $error("input stalled with a free pipeline stage");

   // input backpressure only comes from a stalled output
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output moves");

   // words in flight change only by accepts on either side
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(stage_valid_ff) ==
                $countones($past(stage_valid_ff))
                + int'($past(req_valid && !req_stall))
                - int'($past(rsp_valid && !rsp_stall))))
      else $error("pipeline lost or duplicated a word");

endmodule
